// File: hdl/tgs_pkg.sv
// shared types, constants and defaults for the granular synthesiser
`default_nettype none
package tgs_pkg;

	// default sizes
	localparam int NGRAINS_DEF     = 8;
	localparam int SOUND_DEPTH_DEF = 65536;
	localparam int ENV_DEPTH_DEF   = 1024;

	// register reset values
	localparam logic [31:0] BASE_INC_RST  = 32'd894785;
	localparam logic [17:0] SRATE_RST     = 18'd48000;
	localparam logic [16:0] TLEN_RST      = 17'd65536;
	localparam logic [10:0] ELEN_RST      = 11'd1024;
	localparam logic [14:0] THRESHOLD_RST = 15'd3;

	// output saturation limits
	localparam int OUT_MAX = 262143;
	localparam int OUT_MIN = -262144;

	typedef enum logic [1:0] {
		MODE_SOUND = 2'd0,
		MODE_ENV   = 2'd1,
		MODE_TICK  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		CFG_BASE_INC    = 3'd0,
		CFG_SAMPLE_RATE = 3'd1,
		CFG_TABLE_LEN   = 3'd2,
		CFG_ENV_LEN     = 3'd3,
		CFG_THRESHOLD   = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE, S_INC, S_PTR, S_PH, S_EMUL, S_ELO, S_EHI, S_AMP,
		S_RTG, S_IDX, S_SLO, S_SHI, S_VAL, S_ACC, S_FIN
	} state_t;

	typedef struct packed {
		logic snd_wr;
		logic env_wr;
		logic tick_ld;
		logic inc_ld;
		logic ptr_upd;
		logic ph_ld;
		logic p_ld;
		logic env_rd_lo;
		logic env_rd_hi;
		logic amp_ld;
		logic rtg;
		logic idx_ld;
		logic snd_rd_lo;
		logic snd_rd_hi;
		logic val_ld;
		logic acc;
		logic out_ld;
	} dp_cmd_t;

	typedef struct packed {
		logic last_grain;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

// File: hdl/tgs_if.sv
// input and output channel interfaces
`default_nettype none
interface tgs_in_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  mode;
	logic        [15:0] table_address;
	logic signed [15:0] table_data;
	logic signed [23:0] pitch;
	logic        [23:0] position;
	logic        [19:0] duration;
	modport source (output valid, mode, table_address, table_data, pitch, position, duration,
		input ready);
	modport sink (input valid, mode, table_address, table_data, pitch, position, duration,
		output ready);
endinterface

interface tgs_out_if;
	logic               valid;
	logic               ready;
	logic signed [18:0] output_sample;
	modport source (output valid, output_sample, input ready);
	modport sink (input valid, output_sample, output ready);
endinterface
`default_nettype wire

// File: hdl/table_granular_synth.sv
// granular synthesiser: one output beat per tick beat, memory reads are registered
// a tick runs the increment and pointer states, then the grain states once per grain, then waits for the output
// each grain does two envelope reads and two sound reads on single port rams
// a tick holds off the input between accepted beats; write beats are taken in idle and leave
// the controller there; the next beat is taken once the controller is back in idle
// reset restores the register defaults, the phase pointer and grain state; the sound and
// envelope memories hold nothing until written and get no clearing pass
`default_nettype none
module table_granular_synth #(
	parameter int NGRAINS     = tgs_pkg::NGRAINS_DEF,
	parameter int SOUND_DEPTH = tgs_pkg::SOUND_DEPTH_DEF,
	parameter int ENV_DEPTH   = tgs_pkg::ENV_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	tgs_in_if.sink           in_ch,
	tgs_out_if.source        out_ch,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata
);
	import tgs_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	tgs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_mode  (in_ch.mode),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tgs_datapath #(
		.NGRAINS     (NGRAINS),
		.SOUND_DEPTH (SOUND_DEPTH),
		.ENV_DEPTH   (ENV_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.table_address (in_ch.table_address),
		.table_data    (in_ch.table_data),
		.pitch         (in_ch.pitch),
		.position      (in_ch.position),
		.duration      (in_ch.duration),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.output_sample (out_ch.output_sample)
	);
endmodule
`default_nettype wire

// File: hdl/tgs_ram.sv
// generic single port ram with registered read
`default_nettype none
module tgs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write or read one word
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end
endmodule
`default_nettype wire

// File: hdl/tgs_datapath.sv
// datapath: config registers, memories, grain state and arithmetic
`default_nettype none
module tgs_datapath #(
	parameter int NGRAINS     = 8,
	parameter int SOUND_DEPTH = 65536,
	parameter int ENV_DEPTH   = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tgs_pkg::dp_cmd_t   cmd,
	output tgs_pkg::dp_stat_t       stat,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_wdata,
	input  wire logic [15:0]        table_address,
	input  wire logic signed [15:0] table_data,
	input  wire logic signed [23:0] pitch,
	input  wire logic [23:0]        position,
	input  wire logic [19:0]        duration,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [18:0]      output_sample
);
	import tgs_pkg::*;

	localparam int GW   = (NGRAINS > 1) ? $clog2(NGRAINS) : 1;
	localparam int SAW  = $clog2(SOUND_DEPTH);
	localparam int EAW  = $clog2(ENV_DEPTH);
	localparam int ELW  = $clog2(ENV_DEPTH + 1);
	localparam int TLW  = $clog2(SOUND_DEPTH + 1);
	localparam int SUMW = 34 + $clog2(NGRAINS) + 1;

	// config registers
	logic [31:0] base_inc_q;
	logic [17:0] srate_q;
	logic [16:0] tlen_cfg_q;
	logic [10:0] elen_cfg_q;
	logic [14:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_inc_q <= BASE_INC_RST;
			srate_q    <= SRATE_RST;
			tlen_cfg_q <= TLEN_RST;
			elen_cfg_q <= ELEN_RST;
			thr_q      <= THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_BASE_INC:    base_inc_q <= cfg_wdata;
				CFG_SAMPLE_RATE: srate_q    <= cfg_wdata[17:0];
				CFG_TABLE_LEN:   tlen_cfg_q <= cfg_wdata[16:0];
				CFG_ENV_LEN:     elen_cfg_q <= cfg_wdata[10:0];
				CFG_THRESHOLD:   thr_q      <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	// clamped lengths
	logic [31:0]    e32, t32;
	logic [ELW-1:0] elen;
	logic [TLW-1:0] tlen;

	always_comb begin
		if (elen_cfg_q < 11'd2) begin
			e32 = 32'd2;
		end else if (32'(elen_cfg_q) > 32'(ENV_DEPTH)) begin
			e32 = 32'(ENV_DEPTH);
		end else begin
			e32 = 32'(elen_cfg_q);
		end
		if (32'(tlen_cfg_q) > 32'(SOUND_DEPTH)) begin
			t32 = 32'(SOUND_DEPTH);
		end else begin
			t32 = 32'(tlen_cfg_q);
		end
		elen = ELW'(e32);
		tlen = TLW'(t32);
	end

	// grain phase offsets, fixed at elaboration
	logic [31:0] off_tab [NGRAINS];
	for (genvar g = 0; g < NGRAINS; g++) begin : g_off
		assign off_tab[g] = 32'((64'(g) << 32) / NGRAINS);
	end

	// tick beat payload
	logic signed [23:0] pitch_q;
	logic        [23:0] pos_q;
	logic        [19:0] dur_q;

	always_ff @(posedge clk) begin
		if (cmd.tick_ld) begin
			pitch_q <= pitch;
			pos_q   <= position;
			dur_q   <= duration;
		end
	end

	// pointer increment and retrigger length products
	logic signed [56:0] inc_q;
	logic        [29:0] newlen_q;
	logic        [37:0] len_prod;

	assign len_prod = 38'(dur_q) * 38'(srate_q);

	always_ff @(posedge clk) begin
		if (cmd.inc_ld) begin
			inc_q    <= 57'(pitch_q) * $signed({25'd0, base_inc_q});
			newlen_q <= len_prod[37:8];
		end
	end

	// phase pointer, grain counter and accumulator
	logic [31:0]            ptr_q;
	logic [GW-1:0]          g_q;
	logic signed [SUMW-1:0] sum_q;
	logic signed [16:0]     amp_q;
	logic signed [16:0]     val_q;
	logic signed [33:0]     wprod;

	assign wprod = val_q * amp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			g_q   <= '0;
		end else if (cmd.ptr_upd) begin
			ptr_q <= ptr_q + inc_q[47:16];
			g_q   <= '0;
		end else if (cmd.acc) begin
			g_q <= g_q + GW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ptr_upd) begin
			sum_q <= '0;
		end else if (cmd.acc) begin
			sum_q <= sum_q + SUMW'(wprod);
		end
	end

	assign stat.last_grain = (g_q == GW'(NGRAINS - 1));

	// grain phase and envelope position
	logic [31:0]       ph_q;
	logic [32+ELW-1:0] p_q;

	always_ff @(posedge clk) begin
		if (cmd.ph_ld) begin
			ph_q <= ptr_q + off_tab[g_q];
		end
		if (cmd.p_ld) begin
			p_q <= (32+ELW)'(ph_q) * (32+ELW)'(elen);
		end
	end

	// envelope neighbours, next wraps to the first point
	logic [EAW-1:0] ei, en;
	logic [ELW-1:0] en_w;
	logic [15:0]    efrac;

	always_comb begin
		ei    = p_q[32 +: EAW];
		en_w  = ELW'(ei) + ELW'(1);
		en    = (en_w >= elen) ? '0 : en_w[EAW-1:0];
		efrac = p_q[31:16];
	end

	// envelope memory
	logic           env_en;
	logic [EAW-1:0] env_addr;
	logic [15:0]    env_rd;
	logic signed [15:0] ex_q;

	always_comb begin
		env_en   = cmd.env_rd_lo | cmd.env_rd_hi |
			(cmd.env_wr & (32'(table_address) < 32'(ENV_DEPTH)));
		env_addr = cmd.env_wr ? EAW'(table_address) : (cmd.env_rd_lo ? ei : en);
	end

	tgs_ram #(.WIDTH(16), .DEPTH(ENV_DEPTH)) u_env_ram (
		.clk   (clk),
		.en    (env_en),
		.we    (cmd.env_wr),
		.addr  (env_addr),
		.wdata (table_data),
		.rdata (env_rd)
	);

	// interpolated envelope level
	logic signed [16:0] ediff;
	logic signed [33:0] eprod;

	always_comb begin
		ediff = 17'($signed(env_rd)) - 17'(ex_q);
		eprod = 34'(ediff) * $signed({18'd0, efrac});
	end

	always_ff @(posedge clk) begin
		if (cmd.env_rd_hi) begin
			ex_q <= env_rd;
		end
		if (cmd.amp_ld) begin
			amp_q <= 17'(ex_q) + eprod[32:16];
		end
	end

	// grain start and length, retriggered on a quiet envelope
	logic [23:0] start_q [NGRAINS];
	logic [29:0] len_q   [NGRAINS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NGRAINS; i++) begin
				start_q[i] <= '0;
				len_q[i]   <= '0;
			end
		end else if (cmd.rtg && (amp_q < $signed({2'b00, thr_q}))) begin
			start_q[g_q] <= pos_q;
			len_q[g_q]   <= newlen_q;
		end
	end

	// sound table position
	logic [38:0] idx_q;
	logic [61:0] tprod;

	assign tprod = 62'(ph_q) * 62'(len_q[g_q]);

	always_ff @(posedge clk) begin
		if (cmd.idx_ld) begin
			idx_q <= 39'(tprod[61:24]) + {7'd0, start_q[g_q], 8'd0};
		end
	end

	logic [22:0] ti;
	logic [23:0] ti1;
	logic [15:0] sfrac;
	logic        lo_ok, hi_ok;

	always_comb begin
		ti    = idx_q[38:16];
		ti1   = 24'(ti) + 24'd1;
		sfrac = idx_q[15:0];
		lo_ok = (32'(ti) < 32'(tlen));
		hi_ok = (32'(ti1) < 32'(tlen));
	end

	// sound memory
	logic           snd_en;
	logic [SAW-1:0] snd_addr;
	logic [15:0]    snd_rd;
	logic signed [15:0] sx_q;

	always_comb begin
		snd_en   = cmd.snd_rd_lo | cmd.snd_rd_hi |
			(cmd.snd_wr & (32'(table_address) < 32'(SOUND_DEPTH)));
		snd_addr = cmd.snd_wr ? SAW'(table_address) :
			(cmd.snd_rd_lo ? SAW'(ti) : SAW'(ti1));
	end

	tgs_ram #(.WIDTH(16), .DEPTH(SOUND_DEPTH)) u_snd_ram (
		.clk   (clk),
		.en    (snd_en),
		.we    (cmd.snd_wr),
		.addr  (snd_addr),
		.wdata (table_data),
		.rdata (snd_rd)
	);

	// interpolated grain sample, zero past the table end
	logic signed [16:0] sx1, sdiff;
	logic signed [33:0] sprod;

	always_comb begin
		sx1   = hi_ok ? 17'($signed(snd_rd)) : 17'sd0;
		sdiff = sx1 - 17'(sx_q);
		sprod = 34'(sdiff) * $signed({18'd0, sfrac});
	end

	always_ff @(posedge clk) begin
		if (cmd.snd_rd_hi) begin
			sx_q <= snd_rd;
		end
		if (cmd.val_ld) begin
			val_q <= lo_ok ? (17'(sx_q) + sprod[32:16]) : 17'sd0;
		end
	end

	// output register with saturation
	logic signed [SUMW-1:0] shifted;
	logic signed [18:0]     sat;
	logic                   out_valid_q;
	logic signed [18:0]     out_q;

	always_comb begin
		shifted = sum_q >>> 15;
		if (shifted > SUMW'(OUT_MAX)) begin
			sat = 19'(OUT_MAX);
		end else if (shifted < SUMW'(OUT_MIN)) begin
			sat = 19'(OUT_MIN);
		end else begin
			sat = 19'(shifted);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_q <= sat;
		end
	end

	assign stat.out_free  = !out_valid_q || out_ready;
	assign out_valid      = out_valid_q;
	assign output_sample  = out_q;
endmodule
`default_nettype wire

// File: hdl/tgs_ctrl.sv
// controller: walks one tick through the grains, dispatches write beats
`default_nettype none
module tgs_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [1:0]       in_mode,
	output logic                  in_ready,
	input  wire tgs_pkg::dp_stat_t stat,
	output tgs_pkg::dp_cmd_t      cmd
);
	import tgs_pkg::*;

	state_t state_q, state_d;
	logic   accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (mode_t'(in_mode) == MODE_TICK)) begin
					state_d = S_INC;
				end
			end
			S_INC:  state_d = S_PTR;
			S_PTR:  state_d = S_PH;
			S_PH:   state_d = S_EMUL;
			S_EMUL: state_d = S_ELO;
			S_ELO:  state_d = S_EHI;
			S_EHI:  state_d = S_AMP;
			S_AMP:  state_d = S_RTG;
			S_RTG:  state_d = S_IDX;
			S_IDX:  state_d = S_SLO;
			S_SLO:  state_d = S_SHI;
			S_SHI:  state_d = S_VAL;
			S_VAL:  state_d = S_ACC;
			S_ACC:  state_d = stat.last_grain ? S_FIN : S_PH;
			S_FIN: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					unique case (mode_t'(in_mode))
						MODE_SOUND: cmd.snd_wr  = 1'b1;
						MODE_ENV:   cmd.env_wr  = 1'b1;
						MODE_TICK:  cmd.tick_ld = 1'b1;
						MODE_NONE:  ;
					endcase
				end
			end
			S_INC:  cmd.inc_ld    = 1'b1;
			S_PTR:  cmd.ptr_upd   = 1'b1;
			S_PH:   cmd.ph_ld     = 1'b1;
			S_EMUL: cmd.p_ld      = 1'b1;
			S_ELO:  cmd.env_rd_lo = 1'b1;
			S_EHI:  cmd.env_rd_hi = 1'b1;
			S_AMP:  cmd.amp_ld    = 1'b1;
			S_RTG:  cmd.rtg       = 1'b1;
			S_IDX:  cmd.idx_ld    = 1'b1;
			S_SLO:  cmd.snd_rd_lo = 1'b1;
			S_SHI:  cmd.snd_rd_hi = 1'b1;
			S_VAL:  cmd.val_ld    = 1'b1;
			S_ACC:  cmd.acc       = 1'b1;
			S_FIN:  cmd.out_ld    = stat.out_free;
			default: ;
		endcase
	end
endmodule
`default_nettype wire
